// File: hw/rtl/bwvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwvs_pkg
// Shared sizes and types for the block and window voltage statistics block.
// ----------------------------------------------------------------------------
package bwvs_pkg;

    // Samples per block, blocks per window, sample width
    localparam int BLOCK_LEN    = 40;
    localparam int WINDOW_DEPTH = 10;
    localparam int SAMPLE_W     = 16;

    // Derived widths
    localparam int CNT_W   = $clog2(BLOCK_LEN + 1);
    localparam int SUM_W   = SAMPLE_W + $clog2(BLOCK_LEN) + 1;
    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int WSUM_W  = SAMPLE_W + $clog2(WINDOW_DEPTH) + 1;
    localparam int DIVR_W  = $clog2(((BLOCK_LEN > WINDOW_DEPTH) ? BLOCK_LEN
                                                                 : WINDOW_DEPTH) + 1);
    localparam int DCNT_W  = $clog2(SUM_W + 1);

    // Rounded-up reciprocal of BLOCK_LEN; the shift leaves enough headroom
    // that the product gives the exact floor for any block sum magnitude
    localparam int BLK_RECIP_SH = SUM_W + CNT_W;
    localparam int BLK_RECIP_W  = BLK_RECIP_SH - $clog2(BLOCK_LEN) + 1;
    localparam int PROD_W       = SUM_W + BLK_RECIP_W;
    localparam logic [BLK_RECIP_W-1:0] BLK_RECIP =
        BLK_RECIP_W'(((64'd1 << BLK_RECIP_SH) + 64'(BLOCK_LEN) - 64'd1) / 64'(BLOCK_LEN));

    // Stream payload widths (whole bytes)
    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_RAW_W   = 6 * SAMPLE_W + FILL_W;
    localparam int M_TDATA_W = ((M_RAW_W + 7) / 8) * 8;

    // Extreme sample values
    localparam logic signed [SAMPLE_W-1:0] VAL_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] VAL_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // One window entry: block mean, minimum and maximum
    typedef struct packed {
        t_sample mean;
        t_sample low;
        t_sample high;
    } t_entry;

endpackage

// File: hw/rtl/block_and_window_voltage_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_and_window_voltage_stats
// Block mean/min/max over fixed-size blocks and a sliding window over the
// most recent blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_axis channel, one signed Q3.12 value per item.
//   Each run of BLOCK_LEN (40) samples forms a block. The sample that closes a
//   block produces one item on m_axis carrying the block mean, min and max
//   together with the mean, min and max over the last WINDOW_DEPTH (10) blocks
//   and the number of blocks held. Other samples produce nothing.
//   Throughput: one sample per cycle inside a block. After the closing sample
//   the block is busy with the block mean (reciprocal multiply), the window
//   memory write, the walk over the window memory, the window mean on a
//   radix-2 divider, and the load of the output register, in that order,
//   and takes no new sample until these are done.
//   Reset (synchronous, active low) restarts the block and empties the window.
//   A stalled receiver holds the result in the output register; samples keep
//   being accepted until the next block closes, which then waits for the
//   register to drain.
// ----------------------------------------------------------------------------
module block_and_window_voltage_stats (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample [15:0]
    input  logic [bwvs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // block_average [15:0], block_min [31:16], block_max [47:32],
    // window_average [63:48], window_min [79:64], window_max [95:80],
    // window_count [99:96], zero [103:100]
    output logic [bwvs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready
);
    import bwvs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVB  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DIVW  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]              r_state;

    // block accumulation
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sum;
    t_sample                 r_low;
    t_sample                 r_high;
    t_sample                 r_blo;
    t_sample                 r_bhi;
    t_sample                 r_bavg;

    // window ring
    t_entry                  mem [WINDOW_DEPTH];
    t_entry                  r_rd_data;
    logic                    r_rd_vld;
    logic [SLOT_W-1:0]       r_slot;
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       r_walk;
    logic signed [WSUM_W-1:0] r_wsum;
    t_sample                 r_wlo;
    t_sample                 r_whi;
    t_sample                 r_wavg;

    // window mean divider; r_dvd also carries the block sum magnitude
    logic [SUM_W-1:0]        r_dvd;
    logic [DIVR_W-1:0]       r_rem;
    logic [DIVR_W-1:0]       r_dsor;
    logic [DCNT_W-1:0]       r_dcnt;
    logic                    r_dneg;

    // output register
    logic [M_TDATA_W-1:0]    r_out;
    logic                    r_out_vld;

    logic                    w_s_acc;
    logic                    w_m_acc;
    t_sample                 w_sample;
    logic signed [SUM_W-1:0] n_sum;
    t_sample                 n_low;
    t_sample                 n_high;
    logic [SUM_W-1:0]        w_sum_mag;
    logic [DIVR_W:0]         w_rem_sh;
    logic [DIVR_W:0]         w_rem_sub;
    logic                    w_qbit;
    logic [SUM_W-1:0]        w_quo;
    logic [PROD_W-1:0]       w_bprod;
    logic [SAMPLE_W:0]       w_bq;
    logic                    w_rd_en;
    logic signed [WSUM_W-1:0] w_wsum_mag;
    t_entry                  w_wr_entry;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_m_acc       = r_out_vld && m_axis_tready;

    // Fold the incoming sample into the running block values
    always_comb begin
        w_sample  = t_sample'(s_axis_tdata[SAMPLE_W-1:0]);
        n_sum     = r_sum + SUM_W'(w_sample);
        n_low     = (w_sample < r_low) ? w_sample : r_low;
        n_high    = (w_sample > r_high) ? w_sample : r_high;
        w_sum_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    // One restoring divide step; quotient bits shift into the dividend
    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[SUM_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_dsor};
        w_qbit    = (w_rem_sh >= {1'b0, r_dsor});
        w_quo     = r_dneg ? SUM_W'(-r_dvd) : r_dvd;
    end

    // Block mean: scale the sum magnitude by the reciprocal, then restore the sign
    assign w_bprod = PROD_W'(r_dvd) * PROD_W'(BLK_RECIP);
    assign w_bq    = r_dneg ? -w_bprod[BLK_RECIP_SH +: SAMPLE_W+1]
                            : w_bprod[BLK_RECIP_SH +: SAMPLE_W+1];

    assign w_rd_en    = (r_state == ST_WALK) && (r_walk < r_fill);
    assign w_wsum_mag = r_wsum[WSUM_W-1] ? -r_wsum : r_wsum;
    assign w_wr_entry = '{mean: r_bavg, low: r_blo, high: r_bhi};

    // Window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            mem[r_slot] <= w_wr_entry;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_walk[SLOT_W-1:0]];
        end
    end

    // Sequencer, accumulators and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_low     <= VAL_MAX;
            r_high    <= VAL_MIN;
            r_slot    <= '0;
            r_fill    <= '0;
            r_walk    <= '0;
            r_rd_vld  <= 1'b0;
            r_dcnt    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            // drain the output register; a reload in ST_OUT takes its place
            if (w_m_acc && r_state != ST_OUT) begin
                r_out_vld <= 1'b0;
            end
            r_rd_vld <= w_rd_en;

            // step the divider while the window mean is running
            if (r_state == ST_DIVW && r_dcnt != '0) begin
                r_rem  <= w_qbit ? w_rem_sub[DIVR_W-1:0] : w_rem_sh[DIVR_W-1:0];
                r_dvd  <= {r_dvd[SUM_W-2:0], w_qbit};
                r_dcnt <= r_dcnt - 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        if (r_cnt == CNT_W'(BLOCK_LEN - 1)) begin
                            // close the block, restart accumulation
                            r_blo   <= n_low;
                            r_bhi   <= n_high;
                            r_dvd   <= w_sum_mag;
                            r_dneg  <= n_sum[SUM_W-1];
                            r_cnt   <= '0;
                            r_sum   <= '0;
                            r_low   <= VAL_MAX;
                            r_high  <= VAL_MIN;
                            r_state <= ST_DIVB;
                        end else begin
                            r_cnt  <= r_cnt + 1'b1;
                            r_sum  <= n_sum;
                            r_low  <= n_low;
                            r_high <= n_high;
                        end
                    end
                end
                ST_DIVB: begin
                    r_bavg  <= w_bq[SAMPLE_W-1:0];
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    // entry goes to memory this cycle; advance the ring
                    r_slot <= (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                    if (r_fill != FILL_W'(WINDOW_DEPTH)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_walk  <= '0;
                    r_wsum  <= '0;
                    r_wlo   <= VAL_MAX;
                    r_whi   <= VAL_MIN;
                    r_state <= ST_WALK;
                end
                ST_WALK: begin
                    if (w_rd_en) begin
                        r_walk <= r_walk + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_wsum <= r_wsum + WSUM_W'(r_rd_data.mean);
                        if (r_rd_data.low < r_wlo) begin
                            r_wlo <= r_rd_data.low;
                        end
                        if (r_rd_data.high > r_whi) begin
                            r_whi <= r_rd_data.high;
                        end
                    end
                    if (!w_rd_en && !r_rd_vld) begin
                        r_dvd   <= SUM_W'(unsigned'(w_wsum_mag));
                        r_dneg  <= r_wsum[WSUM_W-1];
                        r_rem   <= '0;
                        r_dsor  <= DIVR_W'(r_fill);
                        r_dcnt  <= DCNT_W'(SUM_W);
                        r_state <= ST_DIVW;
                    end
                end
                ST_DIVW: begin
                    if (r_dcnt == '0) begin
                        r_wavg  <= w_quo[SAMPLE_W-1:0];
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the output register is free
                    if (!r_out_vld || m_axis_tready) begin
                        r_out     <= M_TDATA_W'({r_fill, r_whi, r_wlo, r_wavg,
                                                 r_bhi, r_blo, r_bavg});
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // window count on a result is between one and the window depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out[6*SAMPLE_W +: FILL_W] != '0 &&
                       r_out[6*SAMPLE_W +: FILL_W] <= FILL_W'(WINDOW_DEPTH)))
        else $error("window count out of range");

    // window extremes enclose the block extremes
    a_window_encloses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |->
            ($signed(r_out[4*SAMPLE_W +: SAMPLE_W]) <= $signed(r_out[SAMPLE_W +: SAMPLE_W]) &&
             $signed(r_out[5*SAMPLE_W +: SAMPLE_W]) >= $signed(r_out[2*SAMPLE_W +: SAMPLE_W])))
        else $error("window min/max do not enclose block min/max");

    // divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVW) |-> r_dsor != '0)
        else $error("divide by zero");

    // walk never passes the fill level
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_walk <= r_fill && r_fill != '0))
        else $error("window walk out of bounds");

    // a finished result is not overwritten before it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> (r_out_vld && $stable(r_out)))
        else $error("output register overwritten while stalled");
`endif

endmodule

// File: tb/sv/block_and_window_voltage_stats_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_and_window_voltage_stats_test
// Self-checking bench for the block and window voltage statistics block.
// A queue of samples feeds a clocked stream driver. The driver also folds
// every accepted sample into a local model of the block and window
// statistics. A clocked monitor compares each result item field by field
// with the oldest prediction. Both sides insert random gaps. The samples are
// shaped into blocks of distinct character: all negative, all positive, pinned
// at an extreme, near zero, constant and full spread.
// ----------------------------------------------------------------------------
module block_and_window_voltage_stats_test;

    import bwvs_pkg::*;

    localparam int MIN_SAMPLES = 1100;
    localparam int MIN_BLOCKS  = 27;
    localparam int TAIL_CYCLES = 200;

    typedef enum int {
        BLK_SPREAD,
        BLK_NEGATIVE,
        BLK_POSITIVE,
        BLK_NEAR_ZERO,
        BLK_FLOOR,
        BLK_CEILING,
        BLK_CONSTANT
    } t_block_kind;

    typedef struct {
        t_sample    blk_mean;
        t_sample    blk_low;
        t_sample    blk_high;
        t_sample    win_mean;
        t_sample    win_low;
        t_sample    win_high;
        logic [3:0] win_count;
    } t_block_stats;

    // DUT ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;

    // Pending samples; a set pause flag holds that sample until all results are in
    logic [SAMPLE_W-1:0]    sample_q[$];
    bit                     pause_q[$];
    t_block_stats           stats_q[$];

    int                     total_samples = 0;
    int                     accepted_samples = 0;
    int                     predicted_blocks = 0;
    int                     seen_blocks = 0;
    int                     mismatches = 0;
    int                     kind_seen[t_block_kind];

    // Local model of the block and window statistics
    int                     blk_taken = 0;
    longint                 blk_sum = 0;
    t_sample                blk_low = VAL_MAX;
    t_sample                blk_high = VAL_MIN;
    t_sample                ring_mean[WINDOW_DEPTH];
    t_sample                ring_low[WINDOW_DEPTH];
    t_sample                ring_high[WINDOW_DEPTH];
    int                     ring_fill = 0;
    int                     ring_slot = 0;
    int                     ring_wraps = 0;

    int                     send_gap = 0;
    bit                     send_steady = 1'b0;
    int                     recv_stall = 0;
    bit                     recv_steady = 1'b0;

    block_and_window_voltage_stats dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #4 i_clk = ~i_clk;

    // Fold one sample into the model; return 1 and the stats when a block closes
    function automatic bit fold_sample(input t_sample s, output t_block_stats r);
        longint  wsum;
        t_sample wlo;
        t_sample whi;
        r = '{default: '0};
        blk_sum += s;
        if (s < blk_low) begin
            blk_low = s;
        end
        if (s > blk_high) begin
            blk_high = s;
        end
        blk_taken++;
        if (blk_taken < BLOCK_LEN) begin
            return 1'b0;
        end
        r.blk_mean = t_sample'(blk_sum / BLOCK_LEN);
        r.blk_low  = blk_low;
        r.blk_high = blk_high;
        blk_taken = 0;
        blk_sum   = 0;
        blk_low   = VAL_MAX;
        blk_high  = VAL_MIN;
        // Overwrite the oldest entry once the ring is full
        ring_mean[ring_slot] = r.blk_mean;
        ring_low[ring_slot]  = r.blk_low;
        ring_high[ring_slot] = r.blk_high;
        if (ring_slot + 1 >= WINDOW_DEPTH) begin
            ring_slot = 0;
            ring_wraps++;
        end else begin
            ring_slot++;
        end
        if (ring_fill < WINDOW_DEPTH) begin
            ring_fill++;
        end
        wsum = 0;
        wlo  = VAL_MAX;
        whi  = VAL_MIN;
        for (int i = 0; i < ring_fill; i++) begin
            wsum += ring_mean[i];
            if (ring_low[i] < wlo) begin
                wlo = ring_low[i];
            end
            if (ring_high[i] > whi) begin
                whi = ring_high[i];
            end
        end
        r.win_mean  = t_sample'(wsum / ring_fill);
        r.win_low   = wlo;
        r.win_high  = whi;
        r.win_count = 4'(ring_fill);
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, with stretches of none at all
    function automatic int pick_gap(inout bit steady);
        int r;
        if ($urandom_range(0, 149) == 0) begin
            steady = ~steady;
        end
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SAMPLE_W-1:0] make_sample(t_block_kind kind,
                                                        logic [SAMPLE_W-1:0] level);
        case (kind)
            BLK_NEGATIVE:  return 16'h8000 | 16'($urandom_range(0, 32767));
            BLK_POSITIVE:  return 16'($urandom_range(0, 32767));
            BLK_NEAR_ZERO: return 16'($signed($urandom_range(0, 16)) - 8);
            BLK_FLOOR:     return ($urandom_range(0, 7) == 0) ? 16'h8001 : 16'h8000;
            BLK_CEILING:   return ($urandom_range(0, 7) == 0) ? 16'h7ffe : 16'h7fff;
            BLK_CONSTANT:  return level;
            default:       return 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH block %0d %s: got %0d expected %0d",
                 seen_blocks, what, got, want);
        mismatches++;
    endtask

    // Stream driver: present pending samples, predict on each acceptance
    always @(posedge i_clk) begin
        t_block_stats st;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_samples++;
                if (fold_sample(t_sample'(s_axis_tdata), st)) begin
                    stats_q.push_back(st);
                    predicted_blocks++;
                end
            end
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0 &&
                             (!pause_q[0] || seen_blocks == predicted_blocks)) begin
                    s_axis_tdata  <= sample_q.pop_front();
                    void'(pause_q.pop_front());
                    s_axis_tvalid <= 1'b1;
                    send_gap = pick_gap(send_steady);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each item against the oldest prediction
    always @(posedge i_clk) begin
        t_block_stats want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (stats_q.size() == 0) begin
                    report_mismatch("result items", seen_blocks + 1, predicted_blocks);
                end else begin
                    want = stats_q.pop_front();
                    if (t_sample'(m_axis_tdata[15:0]) !== want.blk_mean)
                        report_mismatch("block_average", t_sample'(m_axis_tdata[15:0]),
                                        want.blk_mean);
                    if (t_sample'(m_axis_tdata[31:16]) !== want.blk_low)
                        report_mismatch("block_min", t_sample'(m_axis_tdata[31:16]),
                                        want.blk_low);
                    if (t_sample'(m_axis_tdata[47:32]) !== want.blk_high)
                        report_mismatch("block_max", t_sample'(m_axis_tdata[47:32]),
                                        want.blk_high);
                    if (t_sample'(m_axis_tdata[63:48]) !== want.win_mean)
                        report_mismatch("window_average", t_sample'(m_axis_tdata[63:48]),
                                        want.win_mean);
                    if (t_sample'(m_axis_tdata[79:64]) !== want.win_low)
                        report_mismatch("window_min", t_sample'(m_axis_tdata[79:64]),
                                        want.win_low);
                    if (t_sample'(m_axis_tdata[95:80]) !== want.win_high)
                        report_mismatch("window_max", t_sample'(m_axis_tdata[95:80]),
                                        want.win_high);
                    if (m_axis_tdata[99:96] !== want.win_count)
                        report_mismatch("window_count", m_axis_tdata[99:96],
                                        want.win_count);
                    if (m_axis_tdata[M_TDATA_W-1:100] !== '0)
                        report_mismatch("padding", m_axis_tdata[M_TDATA_W-1:100], 0);
                end
                seen_blocks <= seen_blocks + 1;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                recv_stall = pick_gap(recv_steady);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [SAMPLE_W-1:0] directed[];
        t_block_kind         kind;
        logic [SAMPLE_W-1:0] level;
        int                  pos;
        directed = '{
            16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h8001, 16'h7ffe,
            16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0, 16'h1000,
            16'hf000, 16'hfffe, 16'hfffd, 16'h0002, 16'h8000, 16'h8000, 16'h7fff,
            16'h7fff, 16'h4000, 16'hc000, 16'hffff
        };
        kind  = BLK_SPREAD;
        level = '0;
        foreach (directed[k]) begin
            sample_q.push_back(directed[k]);
            pause_q.push_back(1'b0);
        end
        // Random part in block-aligned runs of one character each
        pos = directed.size();
        while (pos < MIN_SAMPLES || pos / BLOCK_LEN < MIN_BLOCKS) begin
            if (pos % BLOCK_LEN == 0) begin
                kind  = t_block_kind'($urandom_range(0, 6));
                level = 16'($urandom);
                kind_seen[kind]++;
            end
            sample_q.push_back(make_sample(kind, level));
            // Hold the sender until all results are in, twice in the run
            pause_q.push_back(pos == 12 * BLOCK_LEN || pos == 27 * BLOCK_LEN);
            pos++;
        end
        total_samples = sample_q.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_samples == total_samples);
        wait (seen_blocks == predicted_blocks);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (stats_q.size() != 0) begin
            report_mismatch("result items", seen_blocks, predicted_blocks);
        end

        $display("Covered %0d samples, %0d blocks checked, window wrapped %0d times",
                 accepted_samples, seen_blocks, ring_wraps);
        $display("Block kinds: spread %0d negative %0d positive %0d near-zero %0d",
                 kind_seen[BLK_SPREAD], kind_seen[BLK_NEGATIVE],
                 kind_seen[BLK_POSITIVE], kind_seen[BLK_NEAR_ZERO]);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout: %0d of %0d samples accepted, %0d of %0d results seen",
                 accepted_samples, total_samples, seen_blocks, predicted_blocks);
        $display("Verification failed");
        $finish;
    end

endmodule
